[rtl/core/stma_pkg.sv]
// Shared constants, codes and control structs for the sparse triplet matrix adder.
`default_nettype none

package stma_pkg;

    // List storage sizing.
    localparam int MAX_ENTRIES = 32;
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Field widths.
    localparam int CMD_W     = 2;
    localparam int ROW_W     = 8;
    localparam int COL_W     = 8;
    localparam int VAL_W     = 16;
    localparam int SUM_W     = 17;
    localparam int IDX_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int DIM_W     = 9;
    localparam int CFG_IDX_W = 4;
    localparam int POS_W     = ROW_W + COL_W;
    localparam int ENTRY_W   = POS_W + VAL_W;

    // Request commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_START  = 2'd2
    } t_cmd;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_ENTRY    = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_ROWS = 4'd0,
        CFG_A_COLS = 4'd1,
        CFG_B_ROWS = 4'd2,
        CFG_B_COLS = 4'd3
    } t_cfg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    wr_a;
        logic    wr_b;
        logic    clr_counts;
        logic    start_merge;
        logic    step;
        logic    push_status;
        logic    push_final;
        t_status status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full_a;
        logic full_b;
        logic dim_ok;
        logic merge_done;
        logic slot_free;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/core/stma_if.sv]
// Request, result and configuration channel interfaces.
`default_nettype none

interface stma_in_if;
    logic                           valid;
    logic                           ready;
    logic [stma_pkg::CMD_W-1:0]     cmd;
    logic [stma_pkg::ROW_W-1:0]     row;
    logic [stma_pkg::COL_W-1:0]     col;
    logic signed [stma_pkg::VAL_W-1:0] value;

    modport source (output valid, cmd, row, col, value, input ready);
    modport sink   (input valid, cmd, row, col, value, output ready);
endinterface

interface stma_out_if;
    logic                              valid;
    logic                              ready;
    logic [stma_pkg::STATUS_W-1:0]     status;
    logic [stma_pkg::ROW_W-1:0]        row_res;
    logic [stma_pkg::COL_W-1:0]        col_res;
    logic signed [stma_pkg::SUM_W-1:0] sum_value;
    logic [stma_pkg::IDX_W-1:0]        entry_index;
    logic                              last;

    modport source (output valid, status, row_res, col_res, sum_value, entry_index, last,
                    input ready);
    modport sink   (input valid, status, row_res, col_res, sum_value, entry_index, last,
                    output ready);
endinterface

interface stma_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [stma_pkg::CFG_IDX_W-1:0] index;
    logic [stma_pkg::DIM_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/stma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                        i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/core/stma_ctrl.sv]
// Controller state machine: decodes requests and sequences the merge.
`default_nettype none

module stma_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic [stma_pkg::CMD_W-1:0] i_cmd,
    output      logic                       o_in_ready,
    input  wire stma_pkg::t_dp_stat         i_stat,
    output      stma_pkg::t_dp_cmd          o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_PUSH    = 4'b0010,
        S_FETCH   = 4'b0100,
        S_COMPARE = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    stma_pkg::t_status r_err, n_err;

    // Next-state and command decode.
    always_comb begin
        n_state     = r_state;
        n_err       = r_err;
        o_cmd       = '0;
        o_cmd.status = r_err;
        o_in_ready  = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (stma_pkg::t_cmd'(i_cmd))
                        stma_pkg::CMD_LOAD_A: begin
                            if (i_stat.full_a) begin
                                n_err   = stma_pkg::ST_FULL;
                                n_state = S_PUSH;
                            end else begin
                                o_cmd.wr_a = 1'b1;
                            end
                        end
                        stma_pkg::CMD_LOAD_B: begin
                            if (i_stat.full_b) begin
                                n_err   = stma_pkg::ST_FULL;
                                n_state = S_PUSH;
                            end else begin
                                o_cmd.wr_b = 1'b1;
                            end
                        end
                        stma_pkg::CMD_START: begin
                            if (!i_stat.dim_ok) begin
                                o_cmd.clr_counts = 1'b1;
                                n_err            = stma_pkg::ST_MISMATCH;
                                n_state          = S_PUSH;
                            end else begin
                                o_cmd.start_merge = 1'b1;
                                n_state           = S_FETCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PUSH: begin
                if (i_stat.slot_free) begin
                    o_cmd.push_status = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_FETCH: begin
                n_state = S_COMPARE;
            end
            S_COMPARE: begin
                if (i_stat.slot_free) begin
                    if (i_stat.merge_done) begin
                        o_cmd.push_final = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = S_FETCH;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_err   <= stma_pkg::ST_FULL;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
        end
    end

endmodule

`default_nettype wire

[rtl/core/stma_dp.sv]
// Datapath: list memories, counts, merge pointers, pending entry and result register.
`default_nettype none

module stma_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire stma_pkg::t_dp_cmd                 i_cmd,
    output      stma_pkg::t_dp_stat                o_stat,
    input  wire logic [stma_pkg::ROW_W-1:0]        i_row,
    input  wire logic [stma_pkg::COL_W-1:0]        i_col,
    input  wire logic [stma_pkg::VAL_W-1:0]        i_value,
    input  wire logic                              i_cfg_valid,
    input  wire logic [stma_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [stma_pkg::DIM_W-1:0]        i_cfg_data,
    input  wire logic                              i_out_ready,
    output      logic                              o_out_valid,
    output      logic [stma_pkg::STATUS_W-1:0]     o_status,
    output      logic [stma_pkg::ROW_W-1:0]        o_row_res,
    output      logic [stma_pkg::COL_W-1:0]        o_col_res,
    output      logic [stma_pkg::SUM_W-1:0]        o_sum_value,
    output      logic [stma_pkg::IDX_W-1:0]        o_entry_index,
    output      logic                              o_last
);

    localparam int CW = stma_pkg::CNT_W;
    localparam int AW = stma_pkg::ADDR_W;

    logic [stma_pkg::DIM_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [CW-1:0]              r_cnt_a, r_cnt_b, r_p, r_q;
    logic [stma_pkg::IDX_W-1:0] r_n;

    logic                       r_pend_valid;
    logic [stma_pkg::POS_W-1:0] r_pend_pos;
    logic [stma_pkg::SUM_W-1:0] r_pend_sum;
    logic [stma_pkg::IDX_W-1:0] r_pend_idx;

    logic                          r_out_valid;
    logic [stma_pkg::STATUS_W-1:0] r_out_status;
    logic [stma_pkg::POS_W-1:0]    r_out_pos;
    logic [stma_pkg::SUM_W-1:0]    r_out_sum;
    logic [stma_pkg::IDX_W-1:0]    r_out_idx;
    logic                          r_out_last;

    logic [stma_pkg::ENTRY_W-1:0] wr_word, rd_a, rd_b;
    logic                         a_avail, b_avail, take_a, take_b, nonzero;
    logic [stma_pkg::POS_W-1:0]   pos_a, pos_b, pos_sel;
    logic [stma_pkg::SUM_W-1:0]   ext_a, ext_b, sum;
    logic                         slot_free;

    assign wr_word = {i_row, i_col, i_value};

    // Entry lists.
    stma_ram #(
        .WIDTH (stma_pkg::ENTRY_W),
        .DEPTH (stma_pkg::MAX_ENTRIES)
    ) u_list_a (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_a),
        .i_wr_addr (r_cnt_a[AW-1:0]),
        .i_wr_data (wr_word),
        .i_rd_addr (r_p[AW-1:0]),
        .o_rd_data (rd_a)
    );

    stma_ram #(
        .WIDTH (stma_pkg::ENTRY_W),
        .DEPTH (stma_pkg::MAX_ENTRIES)
    ) u_list_b (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_b),
        .i_wr_addr (r_cnt_b[AW-1:0]),
        .i_wr_data (wr_word),
        .i_rd_addr (r_q[AW-1:0]),
        .o_rd_data (rd_b)
    );

    // Merge step: pick the smaller position, or both when they are equal.
    always_comb begin
        a_avail = (r_p < r_cnt_a);
        b_avail = (r_q < r_cnt_b);
        pos_a   = rd_a[stma_pkg::ENTRY_W-1:stma_pkg::VAL_W];
        pos_b   = rd_b[stma_pkg::ENTRY_W-1:stma_pkg::VAL_W];
        take_a  = a_avail && (!b_avail || (pos_a <= pos_b));
        take_b  = b_avail && (!a_avail || (pos_b <= pos_a));
        ext_a   = take_a ? {rd_a[stma_pkg::VAL_W-1], rd_a[stma_pkg::VAL_W-1:0]} : '0;
        ext_b   = take_b ? {rd_b[stma_pkg::VAL_W-1], rd_b[stma_pkg::VAL_W-1:0]} : '0;
        sum     = ext_a + ext_b;
        pos_sel = take_a ? pos_a : pos_b;
        nonzero = (sum != '0);
    end

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.full_a     = (r_cnt_a == CW'(stma_pkg::MAX_ENTRIES));
        o_stat.full_b     = (r_cnt_b == CW'(stma_pkg::MAX_ENTRIES));
        o_stat.dim_ok     = (r_a_rows == r_b_rows) && (r_a_cols == r_b_cols);
        o_stat.merge_done = !a_avail && !b_avail;
        o_stat.slot_free  = slot_free;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= stma_pkg::DIM_W'(1);
            r_a_cols <= stma_pkg::DIM_W'(1);
            r_b_rows <= stma_pkg::DIM_W'(1);
            r_b_cols <= stma_pkg::DIM_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                stma_pkg::CFG_A_ROWS: r_a_rows <= i_cfg_data;
                stma_pkg::CFG_A_COLS: r_a_cols <= i_cfg_data;
                stma_pkg::CFG_B_ROWS: r_b_rows <= i_cfg_data;
                stma_pkg::CFG_B_COLS: r_b_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // List fill counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
        end else if (i_cmd.clr_counts || i_cmd.push_final) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
        end else begin
            if (i_cmd.wr_a) begin
                r_cnt_a <= r_cnt_a + CW'(1);
            end
            if (i_cmd.wr_b) begin
                r_cnt_b <= r_cnt_b + CW'(1);
            end
        end
    end

    // Merge pointers, result counter and the held-back pending entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p          <= '0;
            r_q          <= '0;
            r_n          <= '0;
            r_pend_valid <= 1'b0;
        end else if (i_cmd.start_merge) begin
            r_p          <= '0;
            r_q          <= '0;
            r_n          <= '0;
            r_pend_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_p <= r_p + CW'(take_a);
            r_q <= r_q + CW'(take_b);
            if (nonzero) begin
                r_n          <= r_n + stma_pkg::IDX_W'(1);
                r_pend_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && nonzero) begin
            r_pend_pos <= pos_sel;
            r_pend_sum <= sum;
            r_pend_idx <= r_n + stma_pkg::IDX_W'(1);
        end
    end

    // Result register: valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_status || i_cmd.push_final ||
                     (i_cmd.step && nonzero && r_pend_valid)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register: payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_status) begin
            r_out_status <= i_cmd.status;
            r_out_pos    <= '0;
            r_out_sum    <= '0;
            r_out_idx    <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.push_final) begin
            r_out_status <= r_pend_valid ? stma_pkg::ST_ENTRY : stma_pkg::ST_EMPTY;
            r_out_pos    <= r_pend_valid ? r_pend_pos : '0;
            r_out_sum    <= r_pend_valid ? r_pend_sum : '0;
            r_out_idx    <= r_pend_valid ? r_pend_idx : '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.step && nonzero && r_pend_valid) begin
            r_out_status <= stma_pkg::ST_ENTRY;
            r_out_pos    <= r_pend_pos;
            r_out_sum    <= r_pend_sum;
            r_out_idx    <= r_pend_idx;
            r_out_last   <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_row_res     = r_out_pos[stma_pkg::POS_W-1:stma_pkg::COL_W];
    assign o_col_res     = r_out_pos[stma_pkg::COL_W-1:0];
    assign o_sum_value   = r_out_sum;
    assign o_entry_index = r_out_idx;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

[rtl/core/sparse_triplet_matrix_add_unit.sv]
// Top level: sparse matrix addition over row-major triplet lists.
// A load into a full list or a start with mismatched dimensions passes through the
// push state, which writes its single result once the result register is free.
// Merge: each merged position is a list read (fetch), then a compare and add
// (compare); the compare waits while the result register is still held.
// Reset clears both fill counts and sets all four dimension registers to 1.
`default_nettype none

module sparse_triplet_matrix_add_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    stma_in_if.sink   i_req,
    stma_out_if.source o_res,
    stma_cfg_if.sink  i_cfg
);

    stma_pkg::t_dp_cmd  dp_cmd;
    stma_pkg::t_dp_stat dp_stat;
    logic               in_ready;

    assign i_req.ready = in_ready;
    assign i_cfg.ready = 1'b1;

    // Request decoder and merge sequencer.
    stma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_cmd      (i_req.cmd),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Storage, merge arithmetic and result register.
    stma_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_row         (i_req.row),
        .i_col         (i_req.col),
        .i_value       (i_req.value),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_status      (o_res.status),
        .o_row_res     (o_res.row_res),
        .o_col_res     (o_res.col_res),
        .o_sum_value   (o_res.sum_value),
        .o_entry_index (o_res.entry_index),
        .o_last        (o_res.last)
    );

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for the sparse triplet matrix adder: directed and random list merges.

module testbench;
    import stma_pkg::*;

    // Bench timing and stimulus sizing.
    localparam int IDLE_PCT     = 18;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEM_BUDGET  = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int POS_MAX      = (1 << POS_W) - 1;

    // The command code that the block leaves unused.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One result as the bench expects to see it.
    typedef struct packed {
        t_status                 status;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [SUM_W-1:0] sum;
        logic [IDX_W-1:0]        idx;
        logic                    last;
    } t_sum_result;

    logic clk;
    logic rst_n;

    stma_in_if  req_if ();
    stma_out_if res_if ();
    stma_cfg_if cfg_if ();

    sparse_triplet_matrix_add_unit uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .o_res  (res_if),
        .i_cfg  (cfg_if)
    );

    // Mirror of the block's lists, counts and dimension registers.
    logic [ENTRY_W-1:0] model_list_a [MAX_ENTRIES];
    logic [ENTRY_W-1:0] model_list_b [MAX_ENTRIES];
    int                 model_count_a;
    int                 model_count_b;
    logic [DIM_W-1:0]   model_dims [4];

    // Expected results, oldest first, and the merge output still being built.
    t_sum_result expected_sums [$];
    t_sum_result held_sum;
    bit          held_valid;
    int          sum_count;

    // Run bookkeeping.
    int failures;
    int requests_sent;
    int results_checked;
    int status_seen [4];
    int hold_left;
    bit steady;

    // Clock.
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog.
    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // Sign-extended value of a stored triplet.
    function automatic int entry_value(logic [ENTRY_W-1:0] entry);
        int v;
        v = $signed(entry[VAL_W-1:0]);
        return v;
    endfunction

    // A result that carries only a status code.
    function automatic t_sum_result status_only(t_status st);
        t_sum_result r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    // Queue one merged entry; a zero sum is dropped. The newest entry is held back
    // so that the final one can be marked last.
    function automatic void emit_sum(logic [POS_W-1:0] pos, int v);
        t_sum_result r;
        if (v != 0) begin
            if (held_valid) begin
                expected_sums.push_back(held_sum);
            end
            sum_count++;
            r.status   = ST_ENTRY;
            r.row      = pos[POS_W-1:COL_W];
            r.col      = pos[COL_W-1:0];
            r.sum      = v[SUM_W-1:0];
            r.idx      = sum_count[IDX_W-1:0];
            r.last     = 1'b0;
            held_sum   = r;
            held_valid = 1'b1;
        end
    endfunction

    // Work out the results of one accepted request and update the mirrored state.
    function automatic void predict_matrix_sum(logic [CMD_W-1:0] cmd,
                                               logic [ROW_W-1:0] row,
                                               logic [COL_W-1:0] col,
                                               logic [VAL_W-1:0] value);
        int               p;
        int               q;
        logic [POS_W-1:0] pa;
        logic [POS_W-1:0] pb;
        p = 0;
        q = 0;
        if (cmd == CMD_LOAD_A || cmd == CMD_LOAD_B) begin
            if (cmd == CMD_LOAD_A && model_count_a < MAX_ENTRIES) begin
                model_list_a[model_count_a] = {row, col, value};
                model_count_a++;
            end else if (cmd == CMD_LOAD_B && model_count_b < MAX_ENTRIES) begin
                model_list_b[model_count_b] = {row, col, value};
                model_count_b++;
            end else begin
                expected_sums.push_back(status_only(ST_FULL));
            end
        end else if (cmd == CMD_START) begin
            if (model_dims[CFG_A_ROWS] != model_dims[CFG_B_ROWS] ||
                model_dims[CFG_A_COLS] != model_dims[CFG_B_COLS]) begin
                expected_sums.push_back(status_only(ST_MISMATCH));
            end else begin
                held_valid = 1'b0;
                sum_count  = 0;
                // Walk both lists in step, comparing positions as they come.
                while (p < model_count_a && q < model_count_b) begin
                    pa = model_list_a[p][ENTRY_W-1:VAL_W];
                    pb = model_list_b[q][ENTRY_W-1:VAL_W];
                    if (pa == pb) begin
                        emit_sum(pa, entry_value(model_list_a[p]) +
                                     entry_value(model_list_b[q]));
                        p++;
                        q++;
                    end else if (pa < pb) begin
                        emit_sum(pa, entry_value(model_list_a[p]));
                        p++;
                    end else begin
                        emit_sum(pb, entry_value(model_list_b[q]));
                        q++;
                    end
                end
                while (p < model_count_a) begin
                    emit_sum(model_list_a[p][ENTRY_W-1:VAL_W], entry_value(model_list_a[p]));
                    p++;
                end
                while (q < model_count_b) begin
                    emit_sum(model_list_b[q][ENTRY_W-1:VAL_W], entry_value(model_list_b[q]));
                    q++;
                end
                if (held_valid) begin
                    held_sum.last = 1'b1;
                    expected_sums.push_back(held_sum);
                end else begin
                    expected_sums.push_back(status_only(ST_EMPTY));
                end
            end
            model_count_a = 0;
            model_count_b = 0;
        end
    endfunction

    // Report one field that differs from its expectation.
    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    // Result side: random stalls, a long hold-off on demand, none while steady.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk) begin
        t_sum_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (expected_sums.size() == 0) begin
                $display("%0t: unexpected result, status %0d row %0d col %0d sum %0d idx %0d",
                         $time, res_if.status, res_if.row_res, res_if.col_res,
                         res_if.sum_value, res_if.entry_index);
                failures++;
            end else begin
                want = expected_sums.pop_front();
                check_field("status", want.status, res_if.status);
                check_field("row_res", want.row, res_if.row_res);
                check_field("col_res", want.col, res_if.col_res);
                check_field("sum_value", want.sum, res_if.sum_value);
                check_field("entry_index", want.idx, res_if.entry_index);
                check_field("last", want.last, res_if.last);
                results_checked++;
                status_seen[want.status]++;
            end
        end
    end

    // Offer one request and wait until the block takes it. Valid stays high afterwards
    // so back-to-back requests need no gap.
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [ROW_W-1:0] row,
                                logic [COL_W-1:0] col, logic [VAL_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.cmd   <= cmd;
        req_if.row   <= row;
        req_if.col   <= col;
        req_if.value <= value;
        do @(posedge clk); while (!req_if.ready);
        predict_matrix_sum(cmd, row, col, value);
        requests_sent++;
    endtask

    // Load one triplet given by its packed position.
    task automatic send_load_at(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                logic [VAL_W-1:0] value);
        send_request(cmd, pos[POS_W-1:COL_W], pos[COL_W-1:0], value);
    endtask

    // Stop offering requests and let every expected result come out.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one configuration register; valid is left high for the next write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [DIM_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        if (index <= CFG_B_COLS) begin
            model_dims[index[1:0]] = data;
        end
    endtask

    // Set all four dimensions once the block is idle, plus a write to an unused index.
    task automatic set_dims(int a_rows, int a_cols, int b_rows, int b_cols);
        logic [CFG_IDX_W-1:0] junk_index;
        logic [DIM_W-1:0]     junk_data;
        junk_index = CFG_IDX_W'($urandom_range(CFG_B_COLS + 1, (1 << CFG_IDX_W) - 1));
        junk_data  = DIM_W'($urandom);
        wait_drained();
        write_reg(junk_index, junk_data);
        write_reg(CFG_A_ROWS, a_rows[DIM_W-1:0]);
        write_reg(CFG_A_COLS, a_cols[DIM_W-1:0]);
        write_reg(CFG_B_ROWS, b_rows[DIM_W-1:0]);
        write_reg(CFG_B_COLS, b_cols[DIM_W-1:0]);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly any value, with the extremes and zero weighted up.
    function automatic logic [VAL_W-1:0] rand_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return 16'h8000;
        else if (roll < 10) return 16'h7FFF;
        else if (roll < 13) return '0;
        else return VAL_W'($urandom);
    endfunction

    function automatic int pick_dim();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 1;
        else if (roll == 1) return 256;
        else return $urandom_range(1, 256);
    endfunction

    // One merge: a sorted pool of positions split between the lists, some shared
    // (and some of those cancelling), with out-of-order loads and unused commands
    // mixed in as noise, then a start.
    task automatic random_merge(int pool_size, bit shared_only);
        int               cursor;
        int               step_max;
        int               k;
        int               pick;
        logic [VAL_W-1:0] va;
        logic [VAL_W-1:0] vb;
        step_max = 60000 / (pool_size + 1);
        cursor   = $urandom_range(0, step_max);
        for (k = 0; k < pool_size && cursor <= POS_MAX; k++) begin
            pick = shared_only ? 2 : $urandom_range(0, 2);
            va   = rand_value();
            vb   = ($urandom_range(0, 3) == 0) ? -va : rand_value();
            if (pick != 1) send_load_at(CMD_LOAD_A, POS_W'(cursor), va);
            if (pick != 0) send_load_at(CMD_LOAD_B, POS_W'(cursor), vb);
            if ($urandom_range(0, 99) < 4) begin
                send_load_at($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A,
                             POS_W'($urandom), rand_value());
            end
            if ($urandom_range(0, 99) < 3) begin
                send_request(CMD_UNUSED, ROW_W'($urandom), COL_W'($urandom),
                             VAL_W'($urandom));
            end
            cursor += $urandom_range(1, step_max);
        end
        send_request(CMD_START, ROW_W'($urandom), COL_W'($urandom), VAL_W'($urandom));
    endtask

    // Empty sums: nothing loaded, a cancelling pair, a lone zero, then one entry.
    task automatic test_empty_sums();
        send_request(CMD_START, 8'd0, 8'd0, 16'd0);
        send_request(CMD_LOAD_A, 8'd0, 8'd0, 16'd5);
        send_request(CMD_LOAD_B, 8'd0, 8'd0, -16'sd5);
        send_request(CMD_START, 8'd0, 8'd0, 16'd0);
        send_request(CMD_LOAD_A, 8'd3, 8'd4, 16'd0);
        send_request(CMD_START, 8'd0, 8'd0, 16'd0);
        send_request(CMD_LOAD_B, 8'd7, 8'd7, 16'hFFFF);
        send_request(CMD_START, 8'd0, 8'd0, 16'd0);
    endtask

    // Field extremes: corner positions, sums at both ends of the range, an unused command.
    task automatic test_extremes();
        send_request(CMD_LOAD_A, 8'd0, 8'd0, 16'h8000);
        send_request(CMD_LOAD_A, 8'd0, 8'd255, 16'h7FFF);
        send_request(CMD_UNUSED, 8'hFF, 8'hFF, 16'hFFFF);
        send_request(CMD_LOAD_A, 8'd255, 8'd255, 16'h7FFF);
        send_request(CMD_LOAD_B, 8'd0, 8'd0, 16'h8000);
        send_request(CMD_LOAD_B, 8'd128, 8'd0, 16'd1);
        send_request(CMD_LOAD_B, 8'd255, 8'd255, 16'h7FFF);
        send_request(CMD_START, 8'hFF, 8'hFF, 16'hFFFF);
    endtask

    // Dimension check: columns differ, rows differ, then the lists must come back empty.
    task automatic test_dimension_check();
        set_dims(4, 4, 4, 5);
        send_request(CMD_LOAD_A, 8'd1, 8'd1, 16'd9);
        send_request(CMD_LOAD_B, 8'd2, 8'd2, 16'd3);
        send_request(CMD_START, 8'd0, 8'd0, 16'd0);
        set_dims(4, 4, 5, 4);
        send_request(CMD_LOAD_A, 8'd1, 8'd1, 16'd9);
        send_request(CMD_START, 8'd0, 8'd0, 16'd0);
        set_dims(256, 256, 256, 256);
        send_request(CMD_START, 8'd0, 8'd0, 16'd0);
    endtask

    // Fill both lists, overflow each once, then merge the largest possible result.
    task automatic test_list_full();
        int i;
        for (i = 0; i < MAX_ENTRIES; i++) begin
            send_request(CMD_LOAD_A, i[ROW_W-1:0], 8'd0, VAL_W'($urandom_range(1, 32767)));
            send_request(CMD_LOAD_B, i[ROW_W-1:0], 8'd1, VAL_W'($urandom_range(1, 32767)));
        end
        send_request(CMD_LOAD_A, 8'd200, 8'd0, 16'd1);
        send_request(CMD_LOAD_B, 8'd200, 8'd1, 16'd1);
        send_request(CMD_START, 8'd0, 8'd0, 16'd0);
    endtask

    // Hold the result side off while requests keep coming, so the block backs up.
    task automatic test_backpressure();
        int i;
        set_dims(16, 16, 16, 16);
        hold_left = HOLD_CYCLES;
        for (i = 0; i < 20; i++) begin
            send_request(CMD_LOAD_A, i[ROW_W-1:0], 8'd2, rand_value());
            send_request(CMD_LOAD_B, i[ROW_W-1:0], 8'd5, rand_value());
        end
        send_request(CMD_START, 8'd0, 8'd0, 16'd0);
        for (i = 0; i < 8; i++) begin
            send_request(CMD_LOAD_A, i[ROW_W-1:0], i[COL_W-1:0], rand_value());
        end
        send_request(CMD_START, 8'd0, 8'd0, 16'd0);
    endtask

    // Random merges under random dimensions, with one stretch free of idling.
    task automatic test_random_merges();
        int merges;
        int rows;
        int cols;
        merges = 0;
        while (requests_sent < ITEM_BUDGET) begin
            if ($urandom_range(0, 3) == 0) begin
                rows = pick_dim();
                cols = pick_dim();
                if ($urandom_range(0, 3) == 0) set_dims(rows, cols, pick_dim(), pick_dim());
                else set_dims(rows, cols, rows, cols);
            end
            steady = (merges >= 4 && merges < 8);
            if ($urandom_range(0, 19) == 0) random_merge(MAX_ENTRIES + 4, 1'b1);
            else random_merge($urandom_range(0, 12), 1'b0);
            merges++;
        end
        steady = 1'b0;
    endtask

    // Main sequence.
    initial begin
        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.cmd    = CMD_LOAD_A;
        req_if.row    = '0;
        req_if.col    = '0;
        req_if.value  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = CFG_A_ROWS;
        cfg_if.data   = '0;
        res_if.ready  = 1'b0;
        model_count_a = 0;
        model_count_b = 0;
        model_dims[CFG_A_ROWS] = 1;
        model_dims[CFG_A_COLS] = 1;
        model_dims[CFG_B_ROWS] = 1;
        model_dims[CFG_B_COLS] = 1;
        held_valid    = 1'b0;
        sum_count     = 0;
        failures      = 0;
        requests_sent = 0;
        results_checked = 0;
        status_seen   = '{default: 0};
        hold_left     = 0;
        steady        = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_sums();
        test_extremes();
        test_dimension_check();
        test_list_full();
        test_backpressure();
        test_random_merges();
        wait_drained();

        $display("Covered %0d requests and %0d results: %0d sum entries, %0d empty sums,",
                 requests_sent, results_checked, status_seen[ST_ENTRY], status_seen[ST_EMPTY]);
        $display("%0d dimension mismatches and %0d full-list rejections.",
                 status_seen[ST_MISMATCH], status_seen[ST_FULL]);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
